[hw/rtl/bmp_pkg.sv]
// Package for the binomial coefficient modulo prime block.
// Holds the modulus, the Fermat exponent, the sequencer states and the
// request/response types of the bit-serial modular multiplier. No dependencies.
package bmp_pkg;

  localparam int RES_W = 30;
  localparam int CNT_W = 5;

  localparam logic [RES_W-1:0] PRIME_MOD  = 30'd998244353;
  localparam logic [RES_W-1:0] EXP_FERMAT = 30'd998244351;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_FACT,
    S_POW_SQ,
    S_POW_MUL,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic             start;
    logic [RES_W-1:0] a;      // multiplicand, below the modulus
    logic [RES_W-1:0] b;      // multiplier, left aligned, consumed MSB first
    logic [CNT_W-1:0] nbits;  // number of multiplier bits to consume
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] value;
  } mm_rsp_t;

endpackage

[hw/rtl/bmp_modmul.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first,
// with a double compare-and-subtract reduction modulo the prime.
// Depends on bmp_pkg.
module bmp_modmul (
  input  logic            clk,
  input  logic            rst_n,
  input  bmp_pkg::mm_req_t req,
  output bmp_pkg::mm_rsp_t rsp
);
  import bmp_pkg::*;

  logic [RES_W-1:0] acc_r, acc_nxt;
  logic [RES_W-1:0] a_r, a_nxt;
  logic [RES_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;

  logic [31:0] sum;
  logic [32:0] sub1;
  logic [32:0] sub2;
  logic [RES_W-1:0] step_val;

  // One interleaved step: acc = 2*acc + bit*a, then reduce from below 3P
  always_comb begin
    sum  = {1'b0, acc_r, 1'b0} + {2'b00, (b_r[RES_W-1] ? a_r : '0)};
    sub1 = {1'b0, sum} - {3'b000, PRIME_MOD};
    sub2 = {1'b0, sum} - {2'b00, PRIME_MOD, 1'b0};
    priority if (!sub2[32]) begin
      step_val = sub2[RES_W-1:0];
    end else if (!sub1[32]) begin
      step_val = sub1[RES_W-1:0];
    end else begin
      step_val = sum[RES_W-1:0];
    end
  end

  // Load on request, then shift one bit per cycle until the count runs out
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      a_nxt   = req.a;
      b_nxt   = req.b;
      cnt_nxt = req.nbits;
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = step_val;
      b_nxt   = {b_r[RES_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

endmodule

[hw/rtl/binomial_mod_prime.sv]
// Top level: falling product times inverse factorial modulo 998244353.
// Sequences one shared bit-serial modular multiplier (bmp_modmul).
// Depends on bmp_pkg and bmp_modmul.
//
//   channel   ports                               transfer when
//   input     start, busy, in_top/low/fact_n      start && !busy at clk edge
//   result    out_valid, out_value                out_valid high (one cycle)
//
// Each item is worked through on the single multiplier, which consumes one
// multiplier bit per cycle; no new item is taken until the result is out.
// Synchronous active-low reset returns the sequencer to idle and clears the pending-multiply flag and result strobe.
// The receiver cannot stall; busy stays high until the result strobe.
module binomial_mod_prime #(
  parameter int VALUE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [VALUE_BITS-1:0]       in_top,
  input  logic [VALUE_BITS-1:0]       in_low,
  input  logic [VALUE_BITS-1:0]       in_fact_n,
  output logic                        out_valid,
  output logic [bmp_pkg::RES_W-1:0]   out_value
);
  import bmp_pkg::*;

  localparam logic [CNT_W-1:0] FACT_NBITS = CNT_W'(VALUE_BITS);
  localparam logic [CNT_W-1:0] FULL_NBITS = CNT_W'(RES_W);
  localparam logic [CNT_W-1:0] EXP_TOP    = CNT_W'(RES_W - 1);

  state_t state_r, state_nxt;
  logic                  run_r, run_nxt;
  logic [VALUE_BITS-1:0] low_r, low_nxt;
  logic [VALUE_BITS-1:0] fn_r, fn_nxt;
  logic [VALUE_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      ebit_r, ebit_nxt;
  logic [RES_W-1:0]      prod_r, prod_nxt;
  logic [RES_W-1:0]      fact_r, fact_nxt;
  logic [RES_W-1:0]      inv_r, inv_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]      out_value_r, out_value_nxt;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  logic [RES_W-1:0] cnt_wide;

  assign cnt_wide = {cnt_r, {(RES_W-VALUE_BITS){1'b0}}};

  bmp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // Sequencer: product loop, factorial loop, square-and-multiply, final multiply
  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    low_nxt       = low_r;
    fn_nxt        = fn_r;
    cnt_nxt       = cnt_r;
    ebit_nxt      = ebit_r;
    prod_nxt      = prod_r;
    fact_nxt      = fact_r;
    inv_nxt       = inv_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    mm_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          low_nxt   = in_low;
          fn_nxt    = in_fact_n;
          cnt_nxt   = in_top;
          prod_nxt  = RES_W'(1);
          fact_nxt  = RES_W'(1);
          run_nxt   = 1'b0;
          state_nxt = S_PROD;
        end
      end

      S_PROD: begin
        if (!run_r) begin
          if (cnt_r > low_r) begin
            mm_req.start = 1'b1;
            mm_req.a     = prod_r;
            mm_req.b     = cnt_wide;
            mm_req.nbits = FACT_NBITS;
            run_nxt      = 1'b1;
          end else begin
            cnt_nxt   = fn_r;
            state_nxt = S_FACT;
          end
        end else if (mm_rsp.done) begin
          prod_nxt = mm_rsp.value;
          cnt_nxt  = cnt_r - 1'b1;
          run_nxt  = 1'b0;
        end
      end

      S_FACT: begin
        if (!run_r) begin
          if (cnt_r > VALUE_BITS'(1)) begin
            mm_req.start = 1'b1;
            mm_req.a     = fact_r;
            mm_req.b     = cnt_wide;
            mm_req.nbits = FACT_NBITS;
            run_nxt      = 1'b1;
          end else begin
            inv_nxt   = RES_W'(1);
            ebit_nxt  = EXP_TOP;
            state_nxt = S_POW_SQ;
          end
        end else if (mm_rsp.done) begin
          fact_nxt = mm_rsp.value;
          cnt_nxt  = cnt_r - 1'b1;
          run_nxt  = 1'b0;
        end
      end

      S_POW_SQ, S_POW_MUL: begin
        if (!run_r) begin
          mm_req.start = 1'b1;
          mm_req.a     = inv_r;
          mm_req.b     = (state_r == S_POW_SQ) ? inv_r : fact_r;
          mm_req.nbits = FULL_NBITS;
          run_nxt      = 1'b1;
        end else if (mm_rsp.done) begin
          inv_nxt = mm_rsp.value;
          run_nxt = 1'b0;
          if (state_r == S_POW_SQ && EXP_FERMAT[ebit_r]) begin
            state_nxt = S_POW_MUL;
          end else if (ebit_r == '0) begin
            state_nxt = S_FINAL;
          end else begin
            ebit_nxt  = ebit_r - 1'b1;
            state_nxt = S_POW_SQ;
          end
        end
      end

      S_FINAL: begin
        if (!run_r) begin
          mm_req.start = 1'b1;
          mm_req.a     = prod_r;
          mm_req.b     = inv_r;
          mm_req.nbits = FULL_NBITS;
          run_nxt      = 1'b1;
        end else if (mm_rsp.done) begin
          out_value_nxt = mm_rsp.value;
          out_valid_nxt = 1'b1;
          run_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
        run_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
    low_r       <= low_nxt;
    fn_r        <= fn_nxt;
    cnt_r       <= cnt_nxt;
    ebit_r      <= ebit_nxt;
    prod_r      <= prod_nxt;
    fact_r      <= fact_nxt;
    inv_r       <= inv_nxt;
    out_value_r <= out_value_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // A result strobe only follows the final multiply
  a_strobe_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FINAL))
    else $error("result strobe without final multiply");

  // A delivered result is always reduced below the modulus
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r < PRIME_MOD))
    else $error("result not reduced");

  // The multiplier only reports completion while the sequencer waits on it
  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> run_r)
    else $error("multiplier done without pending request");

  // Idle sequencer holds no outstanding multiply
  a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !run_r)
    else $error("multiply pending while idle");

endmodule

[tb/tb_binomial_mod_prime.sv]
`timescale 1ns / 100ps
// Self-checking testbench for binomial_mod_prime: falling product times inverse factorial mod P.
// Depends on bmp_pkg and the binomial_mod_prime RTL; predicts every result in SystemVerilog.
module tb_binomial_mod_prime;

  import bmp_pkg::*;

  localparam int VB        = 12;
  localparam int MUL_CYC   = VB + 2;
  localparam int POW_CYC   = 58 * 32 + 32 + 40;
  localparam int IDLE_PCT  = 16;
  localparam int TAIL_CYC  = 2500;
  localparam int N_RANDOM  = 100;

  typedef struct {
    logic [VB-1:0] top;
    logic [VB-1:0] low;
    logic [VB-1:0] fact_n;
    bit            drain;  // hold off until every outstanding result is back
    bit            quiet;  // present without random gaps
  } job_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic [VB-1:0]      in_top    = '0;
  logic [VB-1:0]      in_low    = '0;
  logic [VB-1:0]      in_fact_n = '0;
  logic               busy;
  logic               out_valid;
  logic [RES_W-1:0]   out_value;

  job_t               pending_jobs[$];
  logic [RES_W-1:0]   binom_expect_q[$];
  bit                 job_loaded  = 1'b0;
  int unsigned        n_sent      = 0;
  int unsigned        n_done      = 0;
  int unsigned        mismatch_cnt = 0;
  longint             cyc_cnt     = 0;
  longint             cyc_limit   = 0;

  binomial_mod_prime #(
    .VALUE_BITS(VB)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_top    (in_top),
    .in_low    (in_low),
    .in_fact_n (in_fact_n),
    .out_valid (out_valid),
    .out_value (out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Product of low+1..top times the Fermat inverse of fact_n!, all mod P.
  function automatic logic [RES_W-1:0] binom_mod_predict(logic [VB-1:0] top,
                                                         logic [VB-1:0] low,
                                                         logic [VB-1:0] fact_n);
    longint unsigned p;
    longint unsigned prod;
    longint unsigned fact;
    longint unsigned base;
    longint unsigned inv;
    longint unsigned e;
    int              k;
    p    = longint'(PRIME_MOD);
    prod = 1;
    fact = 1;
    for (k = int'(top); k > int'(low); k--) prod = (prod * longint'(k)) % p;
    for (k = 2; k <= int'(fact_n); k++) fact = (fact * longint'(k)) % p;
    // square-and-multiply to the power P-2
    inv  = 1;
    base = fact % p;
    e    = p - 2;
    while (e != 0) begin
      if (e[0]) inv = (inv * base) % p;
      base = (base * base) % p;
      e    = e >> 1;
    end
    return RES_W'((prod * inv) % p);
  endfunction

  // Queue one job and grow the cycle budget by its worst-case cost.
  task automatic add_job(int top, int low, int fact_n, bit drain, bit quiet);
    job_t j;
    int   span;
    int   nfact;
    j.top    = VB'(top);
    j.low    = VB'(low);
    j.fact_n = VB'(fact_n);
    j.drain  = drain;
    j.quiet  = quiet;
    pending_jobs.insert(pending_jobs.size(), j);
    span  = (top > low) ? top - low : 0;
    nfact = (fact_n > 1) ? fact_n - 1 : 0;
    cyc_limit += 4 * (longint'(span + nfact) * MUL_CYC + POW_CYC + 200);
  endtask

  // Driver: present the next job, drop start at random, count transfers.
  always @(posedge clk) begin : drv
    job_t nxt;
    bit   loaded;
    bit   took;
    bit   quiet;
    loaded = job_loaded;
    took   = start && !busy;
    quiet  = 1'b0;
    if (!rst_n) begin
      start      <= 1'b0;
      job_loaded <= 1'b0;
      in_top     <= '0;
      in_low     <= '0;
      in_fact_n  <= '0;
    end else begin
      if (took) loaded = 1'b0;
      if (!loaded && pending_jobs.size() != 0 &&
          (!pending_jobs[0].drain || n_done == n_sent + took)) begin
        nxt       = pending_jobs.pop_front();
        in_top    <= nxt.top;
        in_low    <= nxt.low;
        in_fact_n <= nxt.fact_n;
        loaded    = 1'b1;
        quiet     = nxt.quiet;
      end else if (loaded) begin
        quiet = pending_jobs.size() == 0 ? 1'b0 : pending_jobs[0].quiet;
      end
      start      <= loaded && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
      job_loaded <= loaded;
      n_sent     <= n_sent + took;
    end
  end

  // Monitor: check the result strobe first, then record the new transfer.
  always @(posedge clk) begin : mon
    logic [RES_W-1:0] want;
    if (rst_n) begin
      if (out_valid) begin
        if (binom_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d", $time, out_value);
          mismatch_cnt++;
        end else begin
          want = binom_expect_q.pop_front();
          if (out_value !== want) begin
            $display("%0t: value mismatch, expected %0d, got %0d", $time, want, out_value);
            mismatch_cnt++;
          end
        end
        n_done <= n_done + 1;
      end
      if (start && !busy)
        binom_expect_q.insert(binom_expect_q.size(),
                              binom_mod_predict(in_top, in_low, in_fact_n));
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > cyc_limit) begin
      $display("%0t: timeout after %0d cycles", $time, cyc_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stim
    int i;
    int sel;
    int k;
    int lo;
    int tp;
    int fn;
    cyc_limit = 20000 + TAIL_CYC;

    // directed: extremes, empty ranges, small factorials, alternating bits
    add_job(0, 0, 0, 0, 0);
    add_job(1, 0, 1, 0, 0);
    add_job(4095, 4094, 0, 0, 0);
    add_job(4095, 4095, 1, 0, 0);
    add_job(3, 5, 1, 0, 0);
    add_job(10, 5, 5, 0, 1);
    add_job(7, 3, 4, 0, 1);
    add_job(2730, 2720, 10, 0, 0);
    add_job(1365, 1360, 3, 0, 0);
    add_job(4095, 4000, 95, 0, 0);
    add_job(100, 0, 2, 0, 0);
    add_job(2048, 2040, 1, 0, 0);
    add_job(20, 10, 10, 1, 0);
    add_job(0, 4095, 4095, 0, 0);
    add_job(4095, 0, 0, 0, 0);
    add_job(4095, 0, 4095, 0, 0);
    add_job(0, 0, 2730, 0, 0);
    add_job(5, 4, 1365, 0, 0);

    // random: mostly binomial form, some empty ranges, a few large factorials
    for (i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, 48);
      lo  = $urandom_range(0, 4095 - k);
      tp  = lo + k;
      if (sel < 60) begin
        fn = k;
      end else if (sel < 75) begin
        tp = $urandom_range(0, 4095);
        lo = $urandom_range(tp, 4095);
        fn = $urandom_range(0, 48);
      end else if (sel < 97) begin
        fn = $urandom_range(0, 63);
      end else begin
        fn = $urandom_range(0, 4095);
      end
      add_job(tp, lo, fn, i == 50, i >= 30 && i < 60);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every job to transfer and every result to return; sample
    // away from the active edge so all updates of that edge have settled
    while (!(pending_jobs.size() == 0 && !job_loaded && n_done == n_sent &&
             binom_expect_q.size() == 0))
      @(negedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (binom_expect_q.size() != 0)
      $display("%0t: results missing, expected %0d more, got none", $time,
               binom_expect_q.size());
    if (mismatch_cnt == 0 && binom_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_modmul.sv
hw/rtl/binomial_mod_prime.sv
tb/tb_binomial_mod_prime.sv
